// ===== rtl/ansam_pkg.sv =====
// Shared types, constants and lookup tables of the answer tone detector.
package ansam_pkg;

    localparam int BLOCK_LENGTH  = 80;
    localparam int CORDIC_STEPS  = 16;
    localparam int TONE_STEP     = 21;
    localparam int CORDIC_GAIN   = 39797;
    localparam int CORDIC_W      = 28;
    localparam int STEP_W        = $clog2(CORDIC_STEPS);
    localparam int POS_W         = 7;

    localparam logic [1:0] CFG_MIN_BLOCKS    = 2'd0;
    localparam logic [1:0] CFG_MIN_REVERSALS = 2'd1;
    localparam logic [1:0] CFG_REV_THRESHOLD = 2'd2;
    localparam logic [1:0] CFG_AM_RATIO      = 2'd3;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MUL  = 9'b000000010,
        S_ACC  = 9'b000000100,
        S_CORD = 9'b000001000,
        S_STEP = 9'b000010000,
        S_GAIN = 9'b000100000,
        S_RND  = 9'b001000000,
        S_UPD  = 9'b010000000,
        S_EMIT = 9'b100000000
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic acc;
        logic cord_init;
        logic cord_step;
        logic gain;
        logic rnd;
        logic upd;
        logic pres;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic block_end;
        logic cord_last;
        logic out_free;
    } t_status;

    // round(32767*cos(2*pi*m/80)) for m = 0..20
    function automatic logic signed [15:0] quarter_cos(input logic [4:0] m);
        logic signed [15:0] v;
        case (m)
            5'd0:  v = 16'sd32767;  5'd1:  v = 16'sd32666;  5'd2:  v = 16'sd32364;
            5'd3:  v = 16'sd31862;  5'd4:  v = 16'sd31163;  5'd5:  v = 16'sd30273;
            5'd6:  v = 16'sd29196;  5'd7:  v = 16'sd27938;  5'd8:  v = 16'sd26509;
            5'd9:  v = 16'sd24916;  5'd10: v = 16'sd23170;  5'd11: v = 16'sd21280;
            5'd12: v = 16'sd19260;  5'd13: v = 16'sd17121;  5'd14: v = 16'sd14876;
            5'd15: v = 16'sd12539;  5'd16: v = 16'sd10126;  5'd17: v = 16'sd7649;
            5'd18: v = 16'sd5126;   5'd19: v = 16'sd2571;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] cos_ref(input logic [6:0] m);
        logic signed [15:0] v;
        if (m <= 7'd20)      v = quarter_cos(m[4:0]);
        else if (m <= 7'd40) v = -quarter_cos(5'(7'd40 - m));
        else if (m <= 7'd60) v = -quarter_cos(5'(m - 7'd40));
        else                 v = quarter_cos(5'(7'd80 - m));
        return v;
    endfunction

    // round(atan(2^-i) * 65536 / (2*pi))
    function automatic logic [15:0] atan_turns(input logic [STEP_W-1:0] i);
        logic [15:0] v;
        case (5'(i))
            5'd0:  v = 16'd8192; 5'd1:  v = 16'd4836; 5'd2:  v = 16'd2555;
            5'd3:  v = 16'd1297; 5'd4:  v = 16'd651;  5'd5:  v = 16'd326;
            5'd6:  v = 16'd163;  5'd7:  v = 16'd81;   5'd8:  v = 16'd41;
            5'd9:  v = 16'd20;   5'd10: v = 16'd10;   5'd11: v = 16'd5;
            5'd12: v = 16'd3;    5'd13: v = 16'd1;    5'd14: v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/ansam_ctrl.sv =====
// Sequencer: steps one sample through multiply, accumulate and block-end work.
module ansam_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  ansam_pkg::t_status i_status,
    output ansam_pkg::t_cmd   o_cmd,
    output logic              o_in_stall
);

    ansam_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ansam_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ansam_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ansam_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ansam_pkg::S_MUL;
                end
            end
            ansam_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ansam_pkg::S_ACC;
            end
            ansam_pkg::S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_status.block_end ? ansam_pkg::S_CORD : ansam_pkg::S_IDLE;
            end
            ansam_pkg::S_CORD: begin
                o_cmd.cord_init = 1'b1;
                n_state         = ansam_pkg::S_STEP;
            end
            ansam_pkg::S_STEP: begin
                o_cmd.cord_step = 1'b1;
                if (i_status.cord_last) n_state = ansam_pkg::S_GAIN;
            end
            ansam_pkg::S_GAIN: begin
                o_cmd.gain = 1'b1;
                n_state    = ansam_pkg::S_RND;
            end
            ansam_pkg::S_RND: begin
                o_cmd.rnd = 1'b1;
                n_state   = ansam_pkg::S_UPD;
            end
            ansam_pkg::S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = ansam_pkg::S_EMIT;
            end
            ansam_pkg::S_EMIT: begin
                // hold until the output register is free
                o_cmd.pres = i_status.out_free;
                o_cmd.emit = i_status.out_free;
                if (i_status.out_free) n_state = ansam_pkg::S_IDLE;
            end
            default: n_state = ansam_pkg::S_IDLE;
        endcase
    end

endmodule

// ===== rtl/ansam_dp.sv =====
// Datapath: correlators, shared CORDIC, block statistics and output register.
module ansam_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ansam_pkg::t_cmd    i_cmd,
    output ansam_pkg::t_status o_status,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [14:0]        i_cfg_data,
    input  logic signed [15:0] i_sample,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic               o_present,
    output logic               o_reversal_seen,
    output logic [7:0]         o_reversal_total,
    output logic [15:0]        o_blocks_seen,
    output logic [23:0]        o_block_amplitude,
    output logic [15:0]        o_block_phase
);

    localparam int CW = ansam_pkg::CORDIC_W;

    logic [9:0]  r_min_blocks, r_am_ratio;
    logic [7:0]  r_min_rev;
    logic [14:0] r_rev_thr;

    logic signed [15:0] r_sample;
    logic signed [31:0] r_prod_i, r_prod_q;
    logic signed [39:0] r_sum_i, r_sum_q;
    logic [ansam_pkg::POS_W-1:0] r_pos, r_ref;

    logic signed [CW-1:0] r_x, r_y;
    logic [15:0] r_z;
    logic        r_zero;
    logic [ansam_pkg::STEP_W-1:0] r_step;
    logic [42:0] r_gain;
    logic [23:0] r_amp;
    logic [15:0] r_phase;

    logic [15:0] r_last_phase;
    logic        r_last_valid, r_seen, r_present;
    logic [23:0] r_small, r_large;
    logic [7:0]  r_rev_cnt;
    logic [15:0] r_blk_cnt;

    logic [6:0]  w_ref_q, w_ref_next;
    logic signed [24:0] w_xs, w_ys;
    logic signed [CW-1:0] w_xe, w_ye, w_xsh, w_ysh;
    logic [27:0] w_rnd;
    logic [15:0] w_dphase;
    logic [16:0] w_dmag;
    logic        w_rev;
    logic        w_pres;

    assign w_ref_q    = (r_ref >= 7'd20) ? 7'(r_ref - 7'd20) : 7'(r_ref + 7'd60);
    assign w_ref_next = (r_ref >= 7'd59) ? 7'(r_ref - 7'd59) : 7'(r_ref + 7'd21);
    assign w_xs  = 25'(r_sum_i >>> 15);
    assign w_ys  = 25'(r_sum_q >>> 15);
    assign w_xe  = CW'(w_xs);
    assign w_ye  = CW'(w_ys);
    assign w_xsh = r_x >>> r_step;
    assign w_ysh = r_y >>> r_step;
    assign w_rnd = 28'((r_gain + 43'd32768) >> 16);
    assign w_dphase = r_phase - r_last_phase;
    assign w_dmag   = w_dphase[15] ? 17'(17'd65536 - {1'b0, w_dphase}) : {1'b0, w_dphase};
    assign w_rev    = r_last_valid && (w_dmag > {2'b00, r_rev_thr});

    // presence check on the statistics updated for this block
    assign w_pres = (r_blk_cnt >= {6'd0, r_min_blocks}) && (r_rev_cnt >= r_min_rev) &&
                    (r_small != 24'd0) &&
                    ({r_large, 8'd0} > 34'(r_small) * 34'(r_am_ratio));

    assign o_status.block_end = (r_pos == 7'(ansam_pkg::BLOCK_LENGTH - 1));
    assign o_status.cord_last = (r_step == ansam_pkg::STEP_W'(ansam_pkg::CORDIC_STEPS - 1));
    assign o_status.out_free  = !o_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_blocks <= 10'd100;
            r_min_rev    <= 8'd1;
            r_rev_thr    <= 15'd22947;
            r_am_ratio   <= 10'd333;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ansam_pkg::CFG_MIN_BLOCKS:    r_min_blocks <= i_cfg_data[9:0];
                ansam_pkg::CFG_MIN_REVERSALS: r_min_rev    <= i_cfg_data[7:0];
                ansam_pkg::CFG_REV_THRESHOLD: r_rev_thr    <= i_cfg_data;
                ansam_pkg::CFG_AM_RATIO:      r_am_ratio   <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // payload pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_sample <= i_sample;
        if (i_cmd.mul) begin
            r_prod_i <= r_sample * ansam_pkg::cos_ref(r_ref);
            r_prod_q <= r_sample * ansam_pkg::cos_ref(w_ref_q);
        end
        if (i_cmd.cord_init) begin
            r_zero <= (w_xs == 25'sd0) && (w_ys == 25'sd0);
            if (w_xs < 0) begin
                r_x <= -w_xe;
                r_y <= -w_ye;
                r_z <= 16'd32768;
            end else begin
                r_x <= w_xe;
                r_y <= w_ye;
                r_z <= 16'd0;
            end
        end else if (i_cmd.cord_step) begin
            if (r_y >= 0) begin
                r_x <= r_x + w_ysh;
                r_y <= r_y - w_xsh;
                r_z <= r_z + ansam_pkg::atan_turns(r_step);
            end else begin
                r_x <= r_x - w_ysh;
                r_y <= r_y + w_xsh;
                r_z <= r_z - ansam_pkg::atan_turns(r_step);
            end
        end
        if (i_cmd.gain) begin
            r_gain <= (r_x < 0) ? 43'd0
                    : 43'(r_x[CW-2:0]) * 43'(ansam_pkg::CORDIC_GAIN);
        end
        if (i_cmd.rnd) begin
            r_amp   <= (w_rnd > 28'hFFFFFF) ? 24'hFFFFFF : w_rnd[23:0];
            r_phase <= r_zero ? 16'd0 : r_z;
        end
        if (i_cmd.upd) r_seen <= w_rev;
        if (i_cmd.emit) begin
            o_present         <= r_present || w_pres;
            o_reversal_seen   <= r_seen;
            o_reversal_total  <= r_rev_cnt;
            o_blocks_seen     <= r_blk_cnt;
            o_block_amplitude <= r_amp;
            o_block_phase     <= r_phase;
        end
    end

    // control-side state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_i      <= '0;
            r_sum_q      <= '0;
            r_pos        <= '0;
            r_ref        <= '0;
            r_step       <= '0;
            r_last_phase <= '0;
            r_last_valid <= 1'b0;
            r_small      <= 24'hFFFFFF;
            r_large      <= '0;
            r_rev_cnt    <= '0;
            r_blk_cnt    <= '0;
            r_present    <= 1'b0;
            o_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.acc) begin
                r_sum_i <= r_sum_i + 40'(r_prod_i);
                r_sum_q <= r_sum_q - 40'(r_prod_q);
                r_pos   <= 7'(r_pos + 7'd1);
                r_ref   <= w_ref_next;
            end
            if (i_cmd.cord_init) begin
                // clear for the next block once the sums are taken
                r_sum_i <= '0;
                r_sum_q <= '0;
                r_pos   <= '0;
                r_ref   <= '0;
                r_step  <= '0;
            end else if (i_cmd.cord_step) begin
                r_step <= r_step + 1'b1;
            end
            if (i_cmd.upd) begin
                if (r_amp < r_small) r_small <= r_amp;
                if (r_amp > r_large) r_large <= r_amp;
                if (w_rev && r_rev_cnt != 8'hFF) r_rev_cnt <= r_rev_cnt + 8'd1;
                if (r_blk_cnt != 16'hFFFF) r_blk_cnt <= r_blk_cnt + 16'd1;
                r_last_phase <= r_phase;
                r_last_valid <= 1'b1;
            end
            if (i_cmd.pres && w_pres) begin
                r_present <= 1'b1;
            end
            if (i_cmd.emit) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/answer_tone_am_detector.sv =====
// Top level of the 2100 Hz answer tone detector with amplitude modulation check.
//
//   channel  direction  handshake                 payload
//   input    in         i_in_valid / o_in_stall    i_sample
//   output   out        o_out_valid / i_out_stall  o_present .. o_block_phase
//   config   in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// A sample passes through register, multiply and accumulate steps; input
// stall is high while a sample is in work, so the next beat waits for idle.
// The 80th sample adds block-end work, set by the 16 CORDIC iterations on
// one shared shift-add unit, plus gain and statistics steps.
// Reset is synchronous and resets all control and statistics state.
// A stalled result beat holds; the next block end waits for it to be taken.
module answer_tone_am_detector (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [14:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_sample,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_present,
    output logic               o_reversal_seen,
    output logic [7:0]         o_reversal_total,
    output logic [15:0]        o_blocks_seen,
    output logic [23:0]        o_block_amplitude,
    output logic [15:0]        o_block_phase
);

    ansam_pkg::t_cmd    w_cmd;
    ansam_pkg::t_status w_status;

    ansam_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    ansam_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_sample          (i_sample),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_present         (o_present),
        .o_reversal_seen   (o_reversal_seen),
        .o_reversal_total  (o_reversal_total),
        .o_blocks_seen     (o_blocks_seen),
        .o_block_amplitude (o_block_amplitude),
        .o_block_phase     (o_block_phase)
    );

    a_emit_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.emit))
        else $error("result beat without block end");

    a_present_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_present) |=> ##0 (!w_cmd.emit || o_present))
        else $error("present flag dropped");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!o_out_valid || !i_out_stall))
        else $error("result overwritten while stalled");

endmodule
